@@ hw/rtl/sbhd_pkg.sv @@
`timescale 1ns / 1ps

package sbhd_pkg;

  localparam int unsigned POS_W = 12;

  localparam logic ENC_BASE64 = 1'b0;
  localparam logic ENC_HEX    = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_OVER    = 2'd2;

  localparam logic [7:0] CH_PAD   = 8'h3d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  localparam logic [5:0] B64_LOWER_BASE = 6'd26;
  localparam logic [5:0] B64_DIGIT_BASE = 6'd52;
  localparam logic [5:0] B64_PLUS       = 6'd62;
  localparam logic [5:0] B64_SLASH      = 6'd63;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
    logic       empty_end;
  } in_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             done_res;
    logic [1:0]       status;
    logic [POS_W-1:0] error_offset;
  } out_t;

  // classified character handed from front to back
  typedef struct packed {
    logic       is_pad;
    logic       b64_ok;
    logic [5:0] b64_val;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       last_char;
    logic       empty_end;
  } mid_t;

endpackage

@@ hw/rtl/strict_base64_hex_text_decoder.sv @@
`timescale 1ns / 1ps
// strict base64 / hex text decoder, one character per transaction
// input queue side: push with in_data while full is low; one character,
// or an empty end marker, per transaction
// result queue side: while empty is low out_data holds the oldest result;
// pop takes it. every input transaction gives exactly one result
// results carry a decoded byte when one completes and, at the end of a
// text, done with status and error offset; on an error status the
// receiver drops the bytes already delivered for that text
// cfg_we writes cfg_wdata as the encoding (0 base64, 1 hex) and drops
// any text in progress; write only while both queues are empty
// throughput: one character per cycle while the result queue is not
// full, sustained, set by the single update stage of the decoder state
// an input is registered in the inner queue and its result in the
// result queue before the result shows; the classify stage feeds a
// two-entry queue and the state update writes a two-entry result queue
// when pop is held low the result queue fills, then the inner queue, and
// full rises; nothing is lost. reset empties both queues, clears the
// decoder state and selects base64

module strict_base64_hex_text_decoder
  import sbhd_pkg::*;
#(
  parameter int unsigned MAX_OUT_BYTES  = 256,
  parameter int unsigned MAX_TEXT_CHARS = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_wdata,
  input  logic push,
  input  in_t  in_data,
  output logic full,
  input  logic pop,
  output out_t out_data,
  output logic empty
);

  localparam logic [POS_W-1:0] POS_CAP =
    (MAX_TEXT_CHARS < 4095) ? POS_W'(MAX_TEXT_CHARS) : POS_W'(4095);
  localparam int unsigned QDEPTH = 2;

  logic enc_r;
  logic mid_full, mid_push, mid_empty, mid_pop;
  mid_t mid_wdata, mid_rdata;
  logic out_full, out_push;
  out_t out_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_r <= ENC_BASE64;
    end else if (cfg_we) begin
      enc_r <= cfg_wdata;
    end
  end

  sbhd_front u_front (
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_data (mid_wdata)
  );

  sbhd_fifo #(.T(mid_t), .DEPTH(QDEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  sbhd_back #(.MAX_OUT_BYTES(MAX_OUT_BYTES), .POS_CAP(POS_CAP)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .enc       (enc_r),
    .clear     (cfg_we),
    .mid_empty (mid_empty),
    .mid_data  (mid_rdata),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_data  (out_wdata)
  );

  sbhd_fifo #(.T(out_t), .DEPTH(QDEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

endmodule

@@ hw/rtl/sbhd_fifo.sv @@
`timescale 1ns / 1ps

module sbhd_fifo #(
  parameter type T = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T                 mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

@@ hw/rtl/sbhd_front.sv @@
`timescale 1ns / 1ps

module sbhd_front
  import sbhd_pkg::*;
(
  input  logic push,
  input  in_t  in_data,
  output logic full,
  input  logic mid_full,
  output logic mid_push,
  output mid_t mid_data
);

  logic [7:0] c;

  assign c        = in_data.text_char;
  assign full     = mid_full;
  assign mid_push = push && !mid_full;

  always_comb begin
    mid_data           = '0;
    mid_data.last_char = in_data.last_char;
    mid_data.empty_end = in_data.empty_end;
    mid_data.is_pad    = (c == CH_PAD);

    // base64 alphabet
    if (c inside {[8'h41:8'h5a]}) begin
      mid_data.b64_ok  = 1'b1;
      mid_data.b64_val = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7a]}) begin
      mid_data.b64_ok  = 1'b1;
      mid_data.b64_val = 6'(c - 8'h61) + B64_LOWER_BASE;
    end else if (c inside {[8'h30:8'h39]}) begin
      mid_data.b64_ok  = 1'b1;
      mid_data.b64_val = 6'(c - 8'h30) + B64_DIGIT_BASE;
    end else if (c == CH_PLUS) begin
      mid_data.b64_ok  = 1'b1;
      mid_data.b64_val = B64_PLUS;
    end else if (c == CH_SLASH) begin
      mid_data.b64_ok  = 1'b1;
      mid_data.b64_val = B64_SLASH;
    end

    // hex digits, a bad one carries all ones
    if (c inside {[8'h30:8'h39]}) begin
      mid_data.hex_ok  = 1'b1;
      mid_data.hex_val = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      mid_data.hex_ok  = 1'b1;
      mid_data.hex_val = 4'(c - 8'h61) + 4'd10;
    end else if (c inside {[8'h41:8'h46]}) begin
      mid_data.hex_ok  = 1'b1;
      mid_data.hex_val = 4'(c - 8'h41) + 4'd10;
    end else begin
      mid_data.hex_ok  = 1'b0;
      mid_data.hex_val = 4'hf;
    end
  end

endmodule

@@ hw/rtl/sbhd_back.sv @@
`timescale 1ns / 1ps

module sbhd_back
  import sbhd_pkg::*;
#(
  parameter int unsigned MAX_OUT_BYTES = 256,
  parameter logic [POS_W-1:0] POS_CAP = 12'd4095
) (
  input  logic clk,
  input  logic rst_n,
  input  logic enc,
  input  logic clear,
  input  logic mid_empty,
  input  mid_t mid_data,
  output logic mid_pop,
  input  logic out_full,
  output logic out_push,
  output out_t out_data
);

  localparam int unsigned BW = $clog2(MAX_OUT_BYTES + 1);

  logic [11:0]      acc_r, acc_nxt;
  logic [2:0]       pb_r, pb_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [BW-1:0]    bytes_r, bytes_nxt;
  logic             pad_seen_r, pad_seen_nxt;
  logic [POS_W-1:0] pad_start_r, pad_start_nxt;
  logic [1:0]       pad_len_r, pad_len_nxt;
  logic             bpo_v_r, bpo_v_nxt;
  logic [POS_W-1:0] bpo_off_r, bpo_off_nxt;
  logic             hn_v_r, hn_v_nxt;
  logic [3:0]       hn_r, hn_nxt;
  logic             err_v_r, err_v_nxt;
  logic             err_over_r, err_over_nxt;
  logic [POS_W-1:0] err_off_r, err_off_nxt;

  logic [3:0]       pb_sum;
  logic             byte_full;
  logic             cap_hit;
  logic             finish;
  logic [POS_W-1:0] d_off;
  logic [1:0]       p_cnt, dm, nm;
  logic             bad_struct;
  logic [11:0]      tail_mask;

  assign mid_pop  = !mid_empty && !out_full;
  assign out_push = mid_pop;
  assign pb_sum   = {1'b0, pb_r} + 4'd6;
  assign byte_full = pb_sum[3];
  assign cap_hit  = (bytes_r >= BW'(MAX_OUT_BYTES));
  assign finish   = mid_data.empty_end || mid_data.last_char;

  always_comb begin
    acc_nxt       = acc_r;
    pb_nxt        = pb_r;
    pos_nxt       = pos_r;
    bytes_nxt     = bytes_r;
    pad_seen_nxt  = pad_seen_r;
    pad_start_nxt = pad_start_r;
    pad_len_nxt   = pad_len_r;
    bpo_v_nxt     = bpo_v_r;
    bpo_off_nxt   = bpo_off_r;
    hn_v_nxt      = hn_v_r;
    hn_nxt        = hn_r;
    err_v_nxt     = err_v_r;
    err_over_nxt  = err_over_r;
    err_off_nxt   = err_off_r;
    out_data      = '0;
    d_off         = '0;
    p_cnt         = '0;
    dm            = '0;
    nm            = '0;
    bad_struct    = 1'b0;
    tail_mask     = '0;

    if (!mid_data.empty_end) begin
      if (enc == ENC_BASE64) begin
        if (pad_seen_r || mid_data.is_pad) begin
          if (!pad_seen_r) begin
            pad_seen_nxt  = 1'b1;
            pad_start_nxt = pos_r;
            pad_len_nxt   = 2'd1;
          end else begin
            if (pad_len_r != 2'd3) begin
              pad_len_nxt = pad_len_r + 2'd1;
            end
            if (!mid_data.is_pad && !bpo_v_r) begin
              bpo_v_nxt   = 1'b1;
              bpo_off_nxt = pos_r;
            end
          end
        end else begin
          pb_nxt = pb_sum[2:0];
          if (!mid_data.b64_ok) begin
            if (!err_v_r) begin
              err_v_nxt    = 1'b1;
              err_over_nxt = 1'b0;
              err_off_nxt  = pos_r;
            end
          end else if (!err_v_r) begin
            acc_nxt = {acc_r[5:0], mid_data.b64_val};
            if (byte_full) begin
              if (cap_hit) begin
                err_v_nxt    = 1'b1;
                err_over_nxt = 1'b1;
                err_off_nxt  = pos_r;
              end else begin
                out_data.out_byte   = 8'(acc_nxt >> pb_nxt);
                out_data.byte_valid = 1'b1;
                bytes_nxt           = bytes_r + BW'(1);
              end
            end
          end
        end
      end else begin
        if (!hn_v_r) begin
          hn_v_nxt      = 1'b1;
          hn_nxt        = mid_data.hex_val;
          pad_start_nxt = pos_r;
          if (!mid_data.hex_ok && !err_v_r) begin
            err_v_nxt    = 1'b1;
            err_over_nxt = 1'b0;
            err_off_nxt  = pos_r;
          end
        end else begin
          hn_v_nxt = 1'b0;
          hn_nxt   = '0;
          if (!mid_data.hex_ok) begin
            if (!err_v_r) begin
              err_v_nxt    = 1'b1;
              err_over_nxt = 1'b0;
              err_off_nxt  = pad_start_r;
            end
          end else if (!err_v_r) begin
            if (cap_hit) begin
              err_v_nxt    = 1'b1;
              err_over_nxt = 1'b1;
              err_off_nxt  = pad_start_r;
            end else begin
              out_data.out_byte   = {hn_r, mid_data.hex_val};
              out_data.byte_valid = 1'b1;
              bytes_nxt           = bytes_r + BW'(1);
            end
          end
        end
      end
      if (pos_r < POS_CAP) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end

    if (finish) begin
      out_data.done_res = 1'b1;
      d_off     = pad_seen_nxt ? pad_start_nxt : pos_nxt;
      p_cnt     = pad_seen_nxt ? pad_len_nxt : 2'd0;
      case (pb_nxt)
        3'd6:    dm = 2'd1;
        3'd4:    dm = 2'd2;
        3'd2:    dm = 2'd3;
        default: dm = 2'd0;
      endcase
      nm        = dm + p_cnt;
      tail_mask = 12'((12'd1 << pb_nxt) - 12'd1);
      bad_struct = (p_cnt == 2'd3) || (p_cnt != 2'd0 && nm != 2'd0) || (dm == 2'd1)
                || (p_cnt == 2'd1 && dm != 2'd3) || (p_cnt == 2'd2 && dm != 2'd2);

      if (enc == ENC_HEX && hn_v_nxt) begin
        out_data.status       = ST_INVALID;
        out_data.error_offset = pos_nxt;
      end else if (enc == ENC_BASE64 && bad_struct) begin
        out_data.status       = ST_INVALID;
        out_data.error_offset = d_off;
      end else if (enc == ENC_BASE64 && bpo_v_nxt) begin
        out_data.status       = ST_INVALID;
        out_data.error_offset = bpo_off_nxt;
      end else if (enc == ENC_BASE64 && !err_v_nxt && pb_nxt != 3'd0
                   && (acc_nxt & tail_mask) != 12'd0) begin
        out_data.status       = ST_INVALID;
        out_data.error_offset = d_off;
      end else if (err_v_nxt) begin
        out_data.status       = err_over_nxt ? ST_OVER : ST_INVALID;
        out_data.error_offset = err_off_nxt;
      end

      acc_nxt       = '0;
      pb_nxt        = '0;
      pos_nxt       = '0;
      bytes_nxt     = '0;
      pad_seen_nxt  = 1'b0;
      pad_start_nxt = '0;
      pad_len_nxt   = '0;
      bpo_v_nxt     = 1'b0;
      bpo_off_nxt   = '0;
      hn_v_nxt      = 1'b0;
      hn_nxt        = '0;
      err_v_nxt     = 1'b0;
      err_over_nxt  = 1'b0;
      err_off_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      acc_r       <= '0;
      pb_r        <= '0;
      pos_r       <= '0;
      bytes_r     <= '0;
      pad_seen_r  <= 1'b0;
      pad_start_r <= '0;
      pad_len_r   <= '0;
      bpo_v_r     <= 1'b0;
      bpo_off_r   <= '0;
      hn_v_r      <= 1'b0;
      hn_r        <= '0;
      err_v_r     <= 1'b0;
      err_over_r  <= 1'b0;
      err_off_r   <= '0;
    end else if (mid_pop) begin
      acc_r       <= acc_nxt;
      pb_r        <= pb_nxt;
      pos_r       <= pos_nxt;
      bytes_r     <= bytes_nxt;
      pad_seen_r  <= pad_seen_nxt;
      pad_start_r <= pad_start_nxt;
      pad_len_r   <= pad_len_nxt;
      bpo_v_r     <= bpo_v_nxt;
      bpo_off_r   <= bpo_off_nxt;
      hn_v_r      <= hn_v_nxt;
      hn_r        <= hn_nxt;
      err_v_r     <= err_v_nxt;
      err_over_r  <= err_over_nxt;
      err_off_r   <= err_off_nxt;
    end
  end

endmodule

@@ dv/text_decode_tb_pkg.sv @@
`timescale 1ns / 1ps

package text_decode_tb_pkg;

  import sbhd_pkg::*;

  localparam int unsigned OUT_LIMIT  = 256;
  localparam int unsigned TEXT_LIMIT = 4096;
  localparam int unsigned POS_CAP    = (TEXT_LIMIT < 4095) ? TEXT_LIMIT : 4095;

  class text_decode_scoreboard;

    bit          hex_mode;
    bit   [11:0] bit_window;
    int unsigned bits_held;
    int unsigned char_pos;
    int unsigned bytes_done;
    bit          pad_seen;
    int unsigned pad_at;
    int unsigned pad_count;
    bit          stray_pad_seen;
    int unsigned stray_pad_at;
    bit          nibble_held;
    bit    [3:0] nibble;
    int unsigned pair_at;
    bit          err_seen;
    bit          err_over;
    int unsigned err_at;
    out_t        cur;
    out_t        decode_q[$];
    int unsigned result_count;
    int unsigned mismatch_count;

    function void clear_text();
      bit_window     = '0;
      bits_held      = 0;
      char_pos       = 0;
      bytes_done     = 0;
      pad_seen       = 0;
      pad_at         = 0;
      pad_count      = 0;
      stray_pad_seen = 0;
      stray_pad_at   = 0;
      nibble_held    = 0;
      nibble         = '0;
      pair_at        = 0;
      err_seen       = 0;
      err_over       = 0;
      err_at         = 0;
    endfunction

    function void set_encoding(logic enc);
      hex_mode = (enc == ENC_HEX);
      clear_text();
    endfunction

    function void keep_error(bit over, int unsigned off);
      if (!err_seen) begin
        err_seen = 1;
        err_over = over;
        err_at   = off;
      end
    endfunction

    function int base64_value(logic [7:0] c);
      if (c >= "A" && c <= "Z") return int'(c - "A");
      if (c >= "a" && c <= "z") return int'(c - "a") + int'(B64_LOWER_BASE);
      if (c >= "0" && c <= "9") return int'(c - "0") + int'(B64_DIGIT_BASE);
      if (c == CH_PLUS) return int'(B64_PLUS);
      if (c == CH_SLASH) return int'(B64_SLASH);
      return -1;
    endfunction

    function int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
    endfunction

    function void base64_char(logic [7:0] c);
      int v;
      bit whole;
      if (pad_seen || c == CH_PAD) begin
        if (!pad_seen) begin
          pad_seen  = 1;
          pad_at    = char_pos;
          pad_count = 1;
        end else begin
          if (pad_count < 3) pad_count++;
          if (c != CH_PAD && !stray_pad_seen) begin
            stray_pad_seen = 1;
            stray_pad_at   = char_pos;
          end
        end
        return;
      end
      v = base64_value(c);
      whole = 0;
      bits_held += 6;
      if (bits_held >= 8) begin
        bits_held -= 8;
        whole = 1;
      end
      if (v < 0) begin
        keep_error(0, char_pos);
        return;
      end
      if (err_seen) return;
      bit_window = {bit_window[5:0], v[5:0]};
      if (whole) begin
        if (bytes_done >= OUT_LIMIT) begin
          keep_error(1, char_pos);
        end else begin
          cur.out_byte   = 8'(bit_window >> bits_held);
          cur.byte_valid = 1'b1;
          bytes_done++;
        end
      end
    endfunction

    function void hex_char(logic [7:0] c);
      int v;
      logic [3:0] hi;
      v = hex_value(c);
      if (!nibble_held) begin
        nibble_held = 1;
        nibble      = v[3:0];
        pair_at     = char_pos;
        if (v < 0) keep_error(0, char_pos);
        return;
      end
      hi = nibble;
      nibble_held = 0;
      if (v < 0) begin
        keep_error(0, pair_at);
        return;
      end
      if (err_seen) return;
      if (bytes_done >= OUT_LIMIT) begin
        keep_error(1, pair_at);
      end else begin
        cur.out_byte   = {hi, v[3:0]};
        cur.byte_valid = 1'b1;
        bytes_done++;
      end
    endfunction

    // status and offset at the end of a text
    function void close_text();
      int unsigned d, p, dm;
      bit settled;
      settled = 0;
      cur.done_res = 1'b1;
      if (hex_mode) begin
        if (nibble_held) begin
          cur.status       = ST_INVALID;
          cur.error_offset = 12'(char_pos);
          settled          = 1;
        end
      end else begin
        d = pad_seen ? pad_at : char_pos;
        p = pad_seen ? pad_count : 0;
        case (bits_held)
          6: dm = 1;
          4: dm = 2;
          2: dm = 3;
          default: dm = 0;
        endcase
        if (p > 2 || (p != 0 && ((dm + p) % 4) != 0) || dm == 1 ||
            (p == 1 && dm != 3) || (p == 2 && dm != 2)) begin
          cur.status       = ST_INVALID;
          cur.error_offset = 12'(d);
          settled          = 1;
        end else if (stray_pad_seen) begin
          cur.status       = ST_INVALID;
          cur.error_offset = 12'(stray_pad_at);
          settled          = 1;
        end else if (!err_seen && bits_held != 0 &&
                     (int'(bit_window) & ((1 << bits_held) - 1)) != 0) begin
          cur.status       = ST_INVALID;
          cur.error_offset = 12'(d);
          settled          = 1;
        end
      end
      if (!settled && err_seen) begin
        cur.status       = err_over ? ST_OVER : ST_INVALID;
        cur.error_offset = 12'(err_at);
      end
    endfunction

    function void decode_char(in_t t);
      cur = '0;
      if (!t.empty_end) begin
        if (hex_mode) hex_char(t.text_char);
        else base64_char(t.text_char);
        if (char_pos < POS_CAP) char_pos++;
        if (!t.last_char) begin
          decode_q = {decode_q, cur};
          return;
        end
      end
      close_text();
      decode_q = {decode_q, cur};
      clear_text();
    endfunction

    task report_mismatch(string what);
      $display("mismatch at result %0d: %s", result_count, what);
      mismatch_count++;
    endtask

    task check_result(out_t got);
      out_t want;
      result_count++;
      if (decode_q.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
        return;
      end
      want = decode_q.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
      if (got.byte_valid !== want.byte_valid)
        report_mismatch($sformatf("byte_valid %b, want %b", got.byte_valid, want.byte_valid));
      if (got.done_res !== want.done_res)
        report_mismatch($sformatf("done_res %b, want %b", got.done_res, want.done_res));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.error_offset !== want.error_offset)
        report_mismatch($sformatf("error_offset %0d, want %0d",
                                  got.error_offset, want.error_offset));
    endtask

  endclass

endpackage

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  import sbhd_pkg::*;
  import text_decode_tb_pkg::*;

  typedef enum int {END_ON_LAST, END_BY_MARKER, END_OPEN} text_end_e;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic cfg_we    = 1'b0;
  logic cfg_wdata = 1'b0;
  logic push      = 1'b0;
  in_t  in_data   = '0;
  logic pop       = 1'b0;
  logic full;
  logic empty;
  out_t out_data;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned sent_count  = 0;
  logic [7:0]  text_buf[$];

  text_decode_scoreboard board = new;

  strict_base64_hex_text_decoder #(
    .MAX_OUT_BYTES  (OUT_LIMIT),
    .MAX_TEXT_CHARS (TEXT_LIMIT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .pop       (pop),
    .out_data  (out_data),
    .empty     (empty)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // values seen here are the ones before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) board.set_encoding(cfg_wdata);
      if (push && !full) board.decode_char(in_data);
      if (pop && !empty) board.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic push_item(in_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (full);
    sent_count++;
  endtask

  task automatic send_text(text_end_e how);
    in_t t;
    int  k;
    for (k = 0; k < text_buf.size(); k++) begin
      t.text_char = text_buf[k];
      t.last_char = (how == END_ON_LAST && k == text_buf.size() - 1);
      t.empty_end = 1'b0;
      push_item(t);
    end
    if (how == END_BY_MARKER || (how == END_ON_LAST && text_buf.size() == 0)) begin
      t.text_char = 8'($urandom_range(0, 255));
      t.last_char = 1'($urandom_range(0, 1));
      t.empty_end = 1'b1;
      push_item(t);
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (board.decode_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_encoding(logic enc);
    cfg_we    <= 1'b1;
    cfg_wdata <= enc;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic void load_text(string s);
    text_buf.delete();
    foreach (s[i]) text_buf = {text_buf, s[i]};
  endfunction

  function automatic logic [7:0] b64_symbol(logic [5:0] v);
    if (v < B64_LOWER_BASE) return "A" + v;
    if (v < B64_DIGIT_BASE) return "a" + (v - B64_LOWER_BASE);
    if (v < B64_PLUS) return "0" + (v - B64_DIGIT_BASE);
    if (v == B64_PLUS) return CH_PLUS;
    return CH_SLASH;
  endfunction

  function automatic logic [7:0] hex_symbol(logic [3:0] nib, bit upper);
    if (nib < 4'd10) return "0" + nib;
    return (upper ? "A" : "a") + (nib - 4'd10);
  endfunction

  function automatic void encode_base64(int n);
    logic [7:0]  raw[$];
    logic [23:0] grp;
    int          k;
    text_buf.delete();
    for (k = 0; k < n; k++) raw = {raw, 8'($urandom_range(0, 255))};
    for (k = 0; k < n; k += 3) begin
      grp = {raw[k], (k + 1 < n) ? raw[k + 1] : 8'h00, (k + 2 < n) ? raw[k + 2] : 8'h00};
      text_buf = {text_buf, b64_symbol(grp[23:18])};
      text_buf = {text_buf, b64_symbol(grp[17:12])};
      text_buf = {text_buf, (k + 1 < n) ? b64_symbol(grp[11:6]) : CH_PAD};
      text_buf = {text_buf, (k + 2 < n) ? b64_symbol(grp[5:0]) : CH_PAD};
    end
  endfunction

  function automatic void encode_hex(int n);
    logic [7:0] b;
    int         k;
    text_buf.delete();
    for (k = 0; k < n; k++) begin
      b = 8'($urandom_range(0, 255));
      text_buf = {text_buf, hex_symbol(b[7:4], 1'($urandom_range(0, 1)))};
      text_buf = {text_buf, hex_symbol(b[3:0], 1'($urandom_range(0, 1)))};
    end
  endfunction

  function automatic void build_base64_text();
    int kind, n, j, r;
    kind = $urandom_range(99);
    if (kind < 70) begin
      encode_base64($urandom_range(0, 10));
      if ($urandom_range(99) < 35) begin
        case ($urandom_range(0, 5))
          0: if (text_buf.size() > 0)
               text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
          1: while (text_buf.size() > 0 && text_buf[$] == CH_PAD) void'(text_buf.pop_back());
          2: text_buf = {text_buf, CH_PAD};
          3: begin
            text_buf = {text_buf, CH_PAD};
            text_buf = {text_buf, b64_symbol(6'($urandom_range(0, 63)))};
          end
          4: begin
            // disturb the trailing bits of the last data character
            j = text_buf.size() - 1;
            while (j >= 0 && text_buf[j] == CH_PAD) j--;
            if (j >= 0) text_buf[j] = b64_symbol(6'($urandom_range(0, 63)));
          end
          default: if (text_buf.size() > 0) void'(text_buf.pop_back());
        endcase
      end
    end else if (kind < 88) begin
      text_buf.delete();
      n = $urandom_range(1, 8);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 60) text_buf = {text_buf, b64_symbol(6'($urandom_range(0, 63)))};
        else if (r < 75) text_buf = {text_buf, CH_PAD};
        else text_buf = {text_buf, 8'($urandom_range(0, 255))};
      end
    end else begin
      text_buf.delete();
    end
  endfunction

  function automatic void build_hex_text();
    int kind, n;
    kind = $urandom_range(99);
    if (kind < 75) begin
      encode_hex($urandom_range(0, 8));
      if ($urandom_range(99) < 35) begin
        case ($urandom_range(0, 2))
          0: if (text_buf.size() > 0)
               text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
          1: if (text_buf.size() > 0) void'(text_buf.pop_back());
          default: text_buf = {text_buf, hex_symbol(4'($urandom_range(0, 15)),
                                                    1'($urandom_range(0, 1)))};
        endcase
      end
    end else if (kind < 90) begin
      text_buf.delete();
      n = $urandom_range(1, 9);
      repeat (n) begin
        if ($urandom_range(99) < 70)
          text_buf = {text_buf, hex_symbol(4'($urandom_range(0, 15)),
                                           1'($urandom_range(0, 1)))};
        else
          text_buf = {text_buf, 8'($urandom_range(0, 255))};
      end
    end else begin
      text_buf.delete();
    end
  endfunction

  initial begin
    int ph, e;
    int unsigned goal;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_encoding(ENC_BASE64);
    load_text("TWE=");
    send_text(END_ON_LAST);
    load_text("+/9*");
    send_text(END_ON_LAST);
    load_text("A");
    send_text(END_ON_LAST);
    load_text("QQ=x");
    send_text(END_ON_LAST);
    load_text("QR==");
    send_text(END_ON_LAST);
    text_buf.delete();
    send_text(END_BY_MARKER);
    settle();

    write_encoding(ENC_HEX);
    load_text("9aF");
    send_text(END_ON_LAST);
    load_text("0G");
    send_text(END_ON_LAST);
    load_text("fF");
    send_text(END_BY_MARKER);
    settle();

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 35;
          rx_idle_pct = 56;
        end
        1: begin
          tx_idle_pct = 56;
          rx_idle_pct = 35;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (e = 0; e < 2; e++) begin
        write_encoding(e[0]);
        goal = sent_count + 8;
        while (sent_count < goal) begin
          if (e == 0) build_base64_text();
          else build_hex_text();
          send_text(($urandom_range(99) < 80) ? END_ON_LAST : END_BY_MARKER);
        end
        // text left open, dropped by the next register write
        if (e == 0) build_base64_text();
        else build_hex_text();
        send_text(END_OPEN);
        settle();
      end
    end

    // output cap
    write_encoding(ENC_BASE64);
    encode_base64(257);
    send_text(END_ON_LAST);
    settle();

    if (board.mismatch_count == 0 && board.decode_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/sbhd_pkg.sv
hw/rtl/sbhd_fifo.sv
hw/rtl/sbhd_front.sv
hw/rtl/sbhd_back.sv
hw/rtl/strict_base64_hex_text_decoder.sv
dv/text_decode_tb_pkg.sv
dv/tb_top.sv
